// File: src/sha1bsh_pkg.sv
// Package for the SHA-1 byte stream hasher: controller/datapath command and
// status types, state encoding, and the fixed SHA-1 constants.
// No dependencies.
package sha1bsh_pkg;

    // SHA-1 initial chaining words
    localparam logic [31:0] IV_H0 = 32'h67452301;
    localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_H2 = 32'h98BADCFE;
    localparam logic [31:0] IV_H3 = 32'h10325476;
    localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    localparam int unsigned NUM_WORDS  = 5;

    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [6:0] ROUND_PAR1    = 7'd20;
    localparam logic [6:0] ROUND_MAJ     = 7'd40;
    localparam logic [6:0] ROUND_PAR2    = 7'd60;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Source of the byte shifted into the block window
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // Round function group
    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    typedef struct packed {
        logic      push;
        byte_src_t src;
        logic      len_load;
        logic      vars_load;
        logic      round_en;
        phase_t    phase;
        logic      chain_add;
        logic      init;
        logic [2:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic fill_last;   // 63 bytes buffered, next push completes a block
        logic fill_at56;   // 56 bytes buffered, room left only for the length
    } sts_t;

endpackage

// File: src/sha1bsh_ctrl.sv
// Controller for the SHA-1 byte stream hasher: sequences byte intake,
// padding, the 80 compression rounds and digest delivery.
// Depends on sha1bsh_pkg.
module sha1bsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                byte_valid,
    input  logic                message_end,
    output logic                digest_valid,
    input  logic                digest_ready,
    output logic [2:0]          word_index,
    output logic                last_word,
    output sha1bsh_pkg::cmd_t   cmd,
    input  sha1bsh_pkg::sts_t   sts
);

    sha1bsh_pkg::state_t state_reg, state_next;
    sha1bsh_pkg::state_t ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;

    logic item_take;
    logic out_take;

    assign item_take = item_valid && (state_reg == sha1bsh_pkg::ST_IDLE);
    assign out_take  = digest_ready && (state_reg == sha1bsh_pkg::ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1bsh_pkg::ST_IDLE;
            ret_reg   <= sha1bsh_pkg::ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        case (state_reg)
            sha1bsh_pkg::ST_IDLE:
            begin
                if (item_take)
                begin
                    if (byte_valid && sts.fill_last)
                    begin
                        state_next = sha1bsh_pkg::ST_LOAD;
                        ret_next   = message_end ? sha1bsh_pkg::ST_PAD_MARK
                                                 : sha1bsh_pkg::ST_IDLE;
                    end
                    else if (message_end)
                    begin
                        state_next = sha1bsh_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha1bsh_pkg::ST_PAD_MARK:
            begin
                if (sts.fill_last)
                begin
                    state_next = sha1bsh_pkg::ST_LOAD;
                    ret_next   = sha1bsh_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    state_next = sha1bsh_pkg::ST_PAD_ZERO;
                end
            end
            sha1bsh_pkg::ST_PAD_ZERO:
            begin
                if (sts.fill_at56)
                begin
                    state_next = sha1bsh_pkg::ST_PAD_LEN;
                end
                else if (sts.fill_last)
                begin
                    state_next = sha1bsh_pkg::ST_LOAD;
                    ret_next   = sha1bsh_pkg::ST_PAD_ZERO;
                end
            end
            sha1bsh_pkg::ST_PAD_LEN:
            begin
                if (sts.fill_last)
                begin
                    state_next = sha1bsh_pkg::ST_LOAD;
                    ret_next   = sha1bsh_pkg::ST_OUT;
                end
            end
            sha1bsh_pkg::ST_LOAD:
            begin
                rnd_next   = '0;
                state_next = sha1bsh_pkg::ST_ROUND;
            end
            sha1bsh_pkg::ST_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == sha1bsh_pkg::LAST_ROUND)
                begin
                    state_next = sha1bsh_pkg::ST_ADD;
                end
            end
            sha1bsh_pkg::ST_ADD:
            begin
                state_next = ret_reg;
            end
            sha1bsh_pkg::ST_OUT:
            begin
                if (out_take)
                begin
                    if (idx_reg == sha1bsh_pkg::LAST_WORD_IDX)
                    begin
                        idx_next   = '0;
                        state_next = sha1bsh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = sha1bsh_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        cmd.src       = sha1bsh_pkg::SRC_DATA;
        cmd.phase     = sha1bsh_pkg::PH_CH;
        cmd.word_idx  = idx_reg;
        item_ready    = 1'b0;
        digest_valid  = 1'b0;
        case (state_reg)
            sha1bsh_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.push   = item_take && byte_valid;
            end
            sha1bsh_pkg::ST_PAD_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.src      = sha1bsh_pkg::SRC_MARK;
                cmd.len_load = 1'b1;
            end
            sha1bsh_pkg::ST_PAD_ZERO:
            begin
                cmd.push = !sts.fill_at56;
                cmd.src  = sha1bsh_pkg::SRC_ZERO;
            end
            sha1bsh_pkg::ST_PAD_LEN:
            begin
                cmd.push = 1'b1;
                cmd.src  = sha1bsh_pkg::SRC_LEN;
            end
            sha1bsh_pkg::ST_LOAD:
            begin
                cmd.vars_load = 1'b1;
            end
            sha1bsh_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (rnd_reg < sha1bsh_pkg::ROUND_PAR1)
                    cmd.phase = sha1bsh_pkg::PH_CH;
                else if (rnd_reg < sha1bsh_pkg::ROUND_MAJ)
                    cmd.phase = sha1bsh_pkg::PH_PAR1;
                else if (rnd_reg < sha1bsh_pkg::ROUND_PAR2)
                    cmd.phase = sha1bsh_pkg::PH_MAJ;
                else
                    cmd.phase = sha1bsh_pkg::PH_PAR2;
            end
            sha1bsh_pkg::ST_ADD:
            begin
                cmd.chain_add = 1'b1;
            end
            sha1bsh_pkg::ST_OUT:
            begin
                digest_valid = 1'b1;
                cmd.init     = out_take && (idx_reg == sha1bsh_pkg::LAST_WORD_IDX);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == sha1bsh_pkg::LAST_WORD_IDX);

endmodule

// File: src/sha1bsh_dp.sv
// Datapath for the SHA-1 byte stream hasher: 512-bit block window that also
// serves as the rolling message schedule, round variables, chaining value,
// byte counters and the length shifter. Depends on sha1bsh_pkg.
module sha1bsh_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha1bsh_pkg::cmd_t   cmd,
    output sha1bsh_pkg::sts_t   sts,
    output logic [31:0]         digest_word
);

    logic [511:0] win_reg, win_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  total_reg, total_next;
    logic [31:0]  chain_reg [sha1bsh_pkg::NUM_WORDS];
    logic [31:0]  var_reg   [sha1bsh_pkg::NUM_WORDS];

    logic [7:0]  push_byte;
    logic [31:0] w_x;
    logic [31:0] w_new;
    logic [31:0] a, b, c, d, e;
    logic [31:0] f_val, k_val, t_val;

    // Byte source
    always_comb
    begin
        case (cmd.src)
            sha1bsh_pkg::SRC_DATA: push_byte = data_byte;
            sha1bsh_pkg::SRC_MARK: push_byte = sha1bsh_pkg::PAD_MARK_BYTE;
            sha1bsh_pkg::SRC_ZERO: push_byte = 8'h00;
            sha1bsh_pkg::SRC_LEN:  push_byte = len_reg[63:56];
            default:               push_byte = 8'h00;
        endcase
    end

    // Oldest word at the top; next schedule word from taps 13, 8, 2 and 0
    assign w_x   = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416]
                 ^ win_reg[511:480];
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb
    begin
        win_next = win_reg;
        if (cmd.push)
            win_next = {win_reg[503:0], push_byte};
        else if (cmd.round_en)
            win_next = {win_reg[479:0], w_new};
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_load)
            len_next = {total_reg, 3'b000};
        else if (cmd.push && (cmd.src == sha1bsh_pkg::SRC_LEN))
            len_next = {len_reg[55:0], 8'h00};
    end

    always_comb
    begin
        fill_next  = fill_reg;
        total_next = total_reg;
        if (cmd.init)
        begin
            fill_next  = '0;
            total_next = '0;
        end
        else if (cmd.push)
        begin
            fill_next = fill_reg + 6'd1;
            if (cmd.src == sha1bsh_pkg::SRC_DATA)
                total_next = total_reg + 61'd1;
        end
    end

    // Round function
    assign a = var_reg[0];
    assign b = var_reg[1];
    assign c = var_reg[2];
    assign d = var_reg[3];
    assign e = var_reg[4];

    always_comb
    begin
        case (cmd.phase)
            sha1bsh_pkg::PH_CH:
            begin
                f_val = (b & c) | (~b & d);
                k_val = sha1bsh_pkg::K_CH;
            end
            sha1bsh_pkg::PH_PAR1:
            begin
                f_val = b ^ c ^ d;
                k_val = sha1bsh_pkg::K_PAR1;
            end
            sha1bsh_pkg::PH_MAJ:
            begin
                f_val = (b & c) | (b & d) | (c & d);
                k_val = sha1bsh_pkg::K_MAJ;
            end
            sha1bsh_pkg::PH_PAR2:
            begin
                f_val = b ^ c ^ d;
                k_val = sha1bsh_pkg::K_PAR2;
            end
            default:
            begin
                f_val = '0;
                k_val = '0;
            end
        endcase
    end

    assign t_val = {a[26:0], a[31:27]} + f_val + e + k_val + win_reg[511:480];

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        len_reg <= len_next;
        if (cmd.vars_load)
        begin
            for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++)
                var_reg[i] <= chain_reg[i];
        end
        else if (cmd.round_en)
        begin
            var_reg[0] <= t_val;
            var_reg[1] <= a;
            var_reg[2] <= {b[1:0], b[31:2]};
            var_reg[3] <= c;
            var_reg[4] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            total_reg    <= '0;
            chain_reg[0] <= sha1bsh_pkg::IV_H0;
            chain_reg[1] <= sha1bsh_pkg::IV_H1;
            chain_reg[2] <= sha1bsh_pkg::IV_H2;
            chain_reg[3] <= sha1bsh_pkg::IV_H3;
            chain_reg[4] <= sha1bsh_pkg::IV_H4;
        end
        else
        begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
            if (cmd.init)
            begin
                chain_reg[0] <= sha1bsh_pkg::IV_H0;
                chain_reg[1] <= sha1bsh_pkg::IV_H1;
                chain_reg[2] <= sha1bsh_pkg::IV_H2;
                chain_reg[3] <= sha1bsh_pkg::IV_H3;
                chain_reg[4] <= sha1bsh_pkg::IV_H4;
            end
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++)
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
            end
        end
    end

    assign sts.fill_last = (fill_reg == 6'd63);
    assign sts.fill_at56 = (fill_reg == 6'd56);

    always_comb
    begin
        case (cmd.word_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = '0;
        endcase
    end

endmodule

// File: src/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher: joins controller and datapath.
// Depends on sha1bsh_pkg, sha1bsh_ctrl and sha1bsh_dp.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+------------------------------------
//  item     | item_valid / item_ready      | data_byte, byte_valid, message_end
//  digest   | digest_valid / digest_ready  | digest_word, word_index, last_word
//
// The 64th byte of a block starts a compression (vars load, 80 rounds at one per
// cycle, chain add) before intake resumes. Message end pads one byte per cycle
// outside compressions, with a pad-zero step that pushes nothing before the length
// bytes. Then the five digest words go out, h0 first; digest_ready low holds the
// current word. rst_n resets controller and counters and loads the chaining value
// with the IV; item_ready is high only when idle.
module sha1_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1bsh_pkg::cmd_t cmd;
    sha1bsh_pkg::sts_t sts;

    // Sequence intake, padding, rounds and digest delivery
    sha1bsh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .byte_valid   (byte_valid),
        .message_end  (message_end),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .word_index   (word_index),
        .last_word    (last_word),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Hold the block window, round state and chaining value
    sha1bsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word)
    );

endmodule

// File: tb/sha1_digest_checker.sv
// Checker for the SHA-1 byte stream hasher: watches the item and digest channels,
// predicts each digest from the accepted bytes, and compares word by word.
// Standalone; it depends only on the signals handed in by the testbench top.
module sha1_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          words_pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] INIT_H0 = 32'h67452301;
    localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
    localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
    localparam logic [31:0] INIT_H3 = 32'h10325476;
    localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;
    localparam logic [31:0] RK_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] RK_PARITY_A = 32'h6ED9EBA1;
    localparam logic [31:0] RK_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] RK_PARITY_B = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam int          FINAL_WORD  = 4;

    typedef enum logic [1:0] {
        GRP_CHOOSE,
        GRP_PARITY_A,
        GRP_MAJORITY,
        GRP_PARITY_B
    } round_group_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_entry_t;

    logic [31:0]   chain_words [5];
    logic [7:0]    block_bytes [64];
    int            fill;
    logic [60:0]   msg_len;
    digest_entry_t digest_words_q [$];
    digest_entry_t want;
    int            words_due = 0;
    int            mismatches = 0;

    assign words_pending = words_due;
    assign fail_count    = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch: %s got %h want %h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic restart_message();
        chain_words[0] = INIT_H0;
        chain_words[1] = INIT_H1;
        chain_words[2] = INIT_H2;
        chain_words[3] = INIT_H3;
        chain_words[4] = INIT_H4;
        fill    = 0;
        msg_len = '0;
    endtask

    // 80 rounds over the current block with a rolling 16-word schedule
    task automatic compress_block();
        logic [31:0]  sched [16];
        logic [31:0]  a, b, c, d, e, f, k, t, x;
        int           r;
        round_group_t grp;
        for (r = 0; r < 16; r++)
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                x = sched[(r-3) & 15] ^ sched[(r-8) & 15] ^ sched[(r-14) & 15]
                  ^ sched[r & 15];
                sched[r & 15] = {x[30:0], x[31]};
            end
            grp = (r < 20) ? GRP_CHOOSE : (r < 40) ? GRP_PARITY_A :
                  (r < 60) ? GRP_MAJORITY : GRP_PARITY_B;
            case (grp)
                GRP_CHOOSE:
                begin
                    f = (b & c) | (~b & d);
                    k = RK_CHOOSE;
                end
                GRP_PARITY_A:
                begin
                    f = b ^ c ^ d;
                    k = RK_PARITY_A;
                end
                GRP_MAJORITY:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = RK_MAJORITY;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = RK_PARITY_B;
                end
            endcase
            t = {a[26:0], a[31:27]} + f + e + k + sched[r & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endtask

    // Pad, append the bit length, queue the five digest words, start over
    task automatic close_message();
        int            pos;
        int            i;
        logic [63:0]   bit_len;
        digest_entry_t entry;
        bit_len = {msg_len, 3'b000};
        pos = fill;
        block_bytes[pos] = PAD_MARK;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (i = 0; i < 8; i++)
            block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        compress_block();
        for (i = 0; i < 5; i++)
        begin
            entry.word    = chain_words[i];
            entry.idx     = i[2:0];
            entry.is_last = (i == FINAL_WORD);
            digest_words_q.push_back(entry);
        end
        words_due += 5;
        restart_message();
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic v, input logic e);
        if (v)
        begin
            block_bytes[fill] = b;
            fill++;
            msg_len = msg_len + 61'd1;
            if (fill == 64)
            begin
                compress_block();
                fill = 0;
            end
        end
        if (e)
            close_message();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_words_q.delete();
            words_due = 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (words_due == 0)
                    report_mismatch("digest word with none expected", digest_word, 32'h0);
                else
                begin
                    want = digest_words_q.pop_front();
                    words_due--;
                    if (digest_word !== want.word)
                        report_mismatch("digest_word", digest_word, want.word);
                    if (word_index !== want.idx)
                        report_mismatch("word_index", {29'd0, word_index}, {29'd0, want.idx});
                    if (last_word !== want.is_last)
                        report_mismatch("last_word", {31'd0, last_word}, {31'd0, want.is_last});
                end
            end
            if (item_valid && item_ready)
                absorb_item(data_byte, byte_valid, message_end);
        end
    end

endmodule

// File: tb/sha1_byte_stream_hasher_test.sv
// Testbench top for the SHA-1 byte stream hasher: drives byte and end-of-message
// transactions with bursty timing, stalls the digest side, and gives the verdict.
// Depends on sha1_byte_stream_hasher and sha1_digest_checker.
module sha1_byte_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 500;   // long digest-side hold-off
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 400;   // two pad blocks plus two compressions

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte    = 8'h00;
    logic        byte_valid   = 1'b0;
    logic        message_end  = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int words_pending;
    int fail_count;
    int burst_left = 0;
    int items_sent = 0;

    sha1_byte_stream_hasher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .message_end  (message_end),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    sha1_digest_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .message_end   (message_end),
        .digest_valid  (digest_valid),
        .digest_ready  (digest_ready),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .last_word     (last_word),
        .words_pending (words_pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item transaction and hold it until accepted. Bursts of random
    // length are separated by random gaps; now and then a long burst runs with
    // no gaps at all. Valid is only lowered when a gap actually starts, so the
    // valid line never sees two assignments in one step.
    task automatic send_item(input logic [7:0] b, input logic v, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid  <= 1'b1;
        data_byte   <= b;
        byte_valid  <= v;
        message_end <= e;
        do
            @(posedge clk);
        while (!(item_valid && item_ready));
        items_sent++;
    endtask

    // Byte content: mostly random, with the all-zero and all-one patterns mixed in
    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Lengths favor short messages and the pad boundaries around 55/56 and 64
    function automatic int pick_length();
        int unsigned sel;
        int          edges [8];
        edges = '{55, 56, 57, 63, 64, 65, 0, 1};
        sel = $urandom_range(0, 9);
        if (sel <= 2)
            return $urandom_range(0, 8);
        if (sel <= 5)
            return edges[$urandom_range(0, 7)];
        if (sel <= 8)
            return $urandom_range(0, 70);
        return $urandom_range(110, 130);
    endfunction

    // Send one message of len bytes. Idle items with junk data are sprinkled in
    // as noise. The end either rides on the last byte or comes as a separate
    // transaction with byte_valid low and random, ignored data.
    task automatic send_message(input int len, input bit end_on_byte);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(pick_byte(), 1'b0, 1'b0);
            send_item(pick_byte(), 1'b1, (end_on_byte && i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_item(pick_byte(), 1'b0, 1'b1);
    endtask

    // Digest side: switch at random among four stall patterns, and once, after ten
    // digest words have gone through, hold ready low for a long stretch while the
    // sender keeps offering items so the block backs up and stalls its input.
    initial
    begin
        int unsigned mode;
        int          cycle_cnt;
        int          taken;
        bit          hold_done;
        mode      = 0;
        cycle_cnt = 0;
        taken     = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (digest_valid && digest_ready)
                taken++;
            if (cycle_cnt % 50 == 0)
                mode = $urandom_range(0, 3);
            cycle_cnt++;
            if (!hold_done && taken >= 10 && digest_valid)
            begin
                digest_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                case (mode)
                    0: digest_ready <= 1'b1;
                    1: digest_ready <= ($urandom_range(0, 1) == 1);
                    2: digest_ready <= (cycle_cnt % 4 == 0);
                    default: digest_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int drain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message with ignored data, "abc" ending on its last
        // byte, idle items, extreme bytes closed by a separate end, one-byte message, a second empty message
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // Random messages until the item budget is spent; finish the last one
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
            send_message(pick_length(), 1'($urandom_range(0, 1)));
        item_valid <= 1'b0;

        // Drain: sample the checker's status away from the active edge
        drain = 0;
        while (words_pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && words_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
src/sha1bsh_pkg.sv
src/sha1bsh_ctrl.sv
src/sha1bsh_dp.sv
src/sha1_byte_stream_hasher.sv
tb/sha1_digest_checker.sv
tb/sha1_byte_stream_hasher_test.sv
